>>> rtl/mcdt_pkg.sv
// Shared types and constants for the multi-channel debounce timer.
`default_nettype none
package mcdt_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int DELAY_W       = 32;
    localparam int CHAN_W        = 4;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CONFIGURE = 2'd0,
        CMD_ARM       = 2'd1,
        CMD_CANCEL    = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [CHAN_W-1:0]  channel;
        logic [DELAY_W-1:0] delay_value;
        logic               periodic;
    } t_req;

    typedef struct packed {
        logic [CHAN_W-1:0] fired_channel;
        logic              last;
    } t_rsp;

    typedef struct packed {
        t_cmd               cmd;
        logic [CHAN_W-1:0]  chan;
        logic [DELAY_W-1:0] delay_value;
        logic               periodic;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

>>> rtl/mcdt_front.sv
// Request intake: accepts requests, drops out-of-range channel requests, feeds the queue.
`default_nettype none
module mcdt_front #(
    parameter int CHANNELS = mcdt_pkg::CHANNELS_DEF
) (
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire mcdt_pkg::t_req   i_req,
    input  wire mcdt_pkg::t_q_stat i_stat,
    output logic                  o_push,
    output mcdt_pkg::t_op         o_op
);

    localparam int IW = (mcdt_pkg::CHAN_W > 8) ? mcdt_pkg::CHAN_W : 8;

    logic          in_range;
    mcdt_pkg::t_cmd cmd;
    logic [IW-1:0] chan_ext;

    assign cmd      = mcdt_pkg::t_cmd'(i_req.command);
    assign chan_ext = IW'(i_req.channel);
    assign in_range = (int'(chan_ext) < CHANNELS);

    assign busy   = i_stat.full || !i_rst_n;
    assign o_push = start && !busy && ((cmd == mcdt_pkg::CMD_TICK) || in_range);

    always_comb begin
        o_op.cmd         = cmd;
        o_op.chan        = i_req.channel;
        o_op.delay_value = i_req.delay_value;
        o_op.periodic    = i_req.periodic;
    end

endmodule
`default_nettype wire

>>> rtl/mcdt_queue.sv
// Short request queue between the intake and the channel engine.
`default_nettype none
module mcdt_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mcdt_pkg::t_op     i_op,
    input  wire logic              i_pop,
    output mcdt_pkg::t_op          o_head,
    output mcdt_pkg::t_q_stat      o_stat
);

    mcdt_pkg::t_op                    r_mem [mcdt_pkg::QUEUE_DEPTH];
    logic [mcdt_pkg::QPTR_W-1:0]      r_wr;
    logic [mcdt_pkg::QPTR_W-1:0]      r_rd;
    logic [mcdt_pkg::QCNT_W-1:0]      r_cnt;

    assign o_stat.full  = (r_cnt == mcdt_pkg::QCNT_W'(mcdt_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + mcdt_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + mcdt_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + mcdt_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - mcdt_pkg::QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/mcdt_back.sv
// Channel engine: executes configure, arm and cancel, and scans the channel table on each tick.
`default_nettype none
module mcdt_back #(
    parameter int CHANNELS  = mcdt_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = mcdt_pkg::TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mcdt_pkg::t_q_stat i_stat,
    input  wire mcdt_pkg::t_op     i_head,
    output logic                   o_pop,
    output logic                   o_strobe,
    output mcdt_pkg::t_rsp         o_rsp
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int IW    = (CH_W > mcdt_pkg::CHAN_W) ? CH_W : mcdt_pkg::CHAN_W;
    localparam int CMP_W = (TIME_BITS > mcdt_pkg::DELAY_W) ? TIME_BITS : mcdt_pkg::DELAY_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARM,
        ST_SCAN
    } t_state;

    t_state                        r_state;
    logic [TIME_BITS-1:0]          r_now;
    logic [CHANNELS-1:0]           r_active;
    logic [CHANNELS-1:0]           r_live_per;
    logic [CHANNELS-1:0]           r_cfg_per;
    logic [CHANNELS-1:0]           r_cfg_valid;
    logic [TIME_BITS-1:0]          r_start_mem [CHANNELS];
    logic [mcdt_pkg::DELAY_W-1:0]  r_live_mem  [CHANNELS];
    logic [mcdt_pkg::DELAY_W-1:0]  r_cfg_mem   [CHANNELS];
    logic [CH_W-1:0]               r_idx;
    logic [mcdt_pkg::DELAY_W-1:0]  r_cfg_rd;
    logic [CNT_W-1:0]              r_scan;
    logic                          r_ev_valid;
    logic [CH_W-1:0]               r_ev_idx;
    logic [TIME_BITS-1:0]          r_rd_start;
    logic [mcdt_pkg::DELAY_W-1:0]  r_rd_delay;
    logic                          r_pend_valid;
    logic [mcdt_pkg::CHAN_W-1:0]   r_pend_ch;
    logic [mcdt_pkg::RES_W-1:0]    r_count;
    logic                          r_strobe;
    mcdt_pkg::t_rsp                r_rsp;

    logic [IW-1:0]                 head_ext;
    logic [CH_W-1:0]               head_idx;
    logic [CH_W-1:0]               scan_idx;
    logic                          scan_rd;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          ev_act;
    logic                          ev_zero;
    logic                          ev_fire;
    logic                          ev_report;
    logic [IW-1:0]                 ev_ext;
    logic                          start_we;
    logic [CH_W-1:0]               start_wa;
    logic                          do_cfg;
    logic                          do_arm;

    assign head_ext  = IW'(i_head.chan);
    assign head_idx  = head_ext[CH_W-1:0];
    assign scan_idx  = r_scan[CH_W-1:0];
    assign scan_rd   = (r_state == ST_SCAN) && (r_scan < CNT_W'(CHANNELS));
    assign o_pop     = (r_state == ST_IDLE) && !i_stat.empty;
    assign do_cfg    = o_pop && (i_head.cmd == mcdt_pkg::CMD_CONFIGURE);
    assign do_arm    = o_pop && (i_head.cmd == mcdt_pkg::CMD_ARM);

    assign elapsed   = r_now - r_rd_start;
    assign ev_act    = r_ev_valid && r_active[r_ev_idx];
    assign ev_zero   = (r_rd_delay == '0);
    assign ev_fire   = ev_act && !ev_zero && (CMP_W'(elapsed) > CMP_W'(r_rd_delay));
    assign ev_report = ev_fire && (r_count < mcdt_pkg::RES_W'(mcdt_pkg::MAX_RESULTS));
    assign ev_ext    = IW'(r_ev_idx);

    assign start_we  = do_arm || (ev_fire && r_live_per[r_ev_idx]);
    assign start_wa  = do_arm ? head_idx : r_ev_idx;

    assign o_strobe  = r_strobe;
    assign o_rsp     = r_rsp;

    always_ff @(posedge i_clk) begin
        if (start_we) begin
            r_start_mem[start_wa] <= r_now;
        end
        if (scan_rd) begin
            r_rd_start <= r_start_mem[scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ARM) begin
            r_live_mem[r_idx] <= r_cfg_rd;
        end
        if (scan_rd) begin
            r_rd_delay <= r_live_mem[scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_cfg) begin
            r_cfg_mem[head_idx] <= i_head.delay_value;
        end
        if (do_arm) begin
            r_cfg_rd <= r_cfg_valid[head_idx] ? r_cfg_mem[head_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_now        <= '0;
            r_active     <= '0;
            r_live_per   <= '0;
            r_cfg_per    <= '0;
            r_cfg_valid  <= '0;
            r_scan       <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (ev_act) begin
                if (ev_zero) begin
                    r_active[r_ev_idx] <= 1'b0;
                end else if (ev_fire) begin
                    if (!r_live_per[r_ev_idx]) begin
                        r_active[r_ev_idx] <= 1'b0;
                    end
                    if (ev_report) begin
                        if (r_pend_valid) begin
                            r_strobe                <= 1'b1;
                            r_rsp.fired_channel     <= r_pend_ch;
                            r_rsp.last              <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_ch    <= ev_ext[mcdt_pkg::CHAN_W-1:0];
                        r_count      <= r_count + mcdt_pkg::RES_W'(1);
                    end
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_stat.empty) begin
                        unique case (i_head.cmd)
                            mcdt_pkg::CMD_CONFIGURE: begin
                                r_cfg_per[head_idx]   <= i_head.periodic;
                                r_cfg_valid[head_idx] <= 1'b1;
                            end
                            mcdt_pkg::CMD_ARM: begin
                                r_active[head_idx]   <= 1'b1;
                                r_live_per[head_idx] <= r_cfg_per[head_idx];
                                r_idx                <= head_idx;
                                r_state              <= ST_ARM;
                            end
                            mcdt_pkg::CMD_CANCEL: begin
                                r_active[head_idx]   <= 1'b0;
                                r_live_per[head_idx] <= 1'b0;
                            end
                            mcdt_pkg::CMD_TICK: begin
                                r_now        <= r_now + TIME_BITS'(1);
                                r_scan       <= '0;
                                r_count      <= '0;
                                r_pend_valid <= 1'b0;
                                r_state      <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_ARM: begin
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    r_ev_valid <= scan_rd;
                    r_ev_idx   <= scan_idx;
                    if (scan_rd) begin
                        r_scan <= r_scan + CNT_W'(1);
                    end else if (!r_ev_valid) begin
                        if (r_pend_valid) begin
                            r_strobe            <= 1'b1;
                            r_rsp.fired_channel <= r_pend_ch;
                            r_rsp.last          <= 1'b1;
                        end
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/multi_channel_debounce_timer.sv
// Top level of the multi-channel retriggerable debounce timer.
//
//   Channel   Control         Payload   Direction
//   request   start / busy    i_req     in
//   result    o_strobe        o_rsp     out
//
// Configure and cancel are executed straight from the idle state, arm also passes
// through ST_ARM, and a tick runs the scan that reads one channel table entry per cycle.
// Requests wait in a four-entry queue; busy is high while that queue is full and during
// reset. Reset is synchronous and clears the counter and channel flags, not the tables.
// Each result shows for exactly one cycle on o_strobe; the receiver cannot stall.
`default_nettype none
module multi_channel_debounce_timer #(
    parameter int CHANNELS  = mcdt_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = mcdt_pkg::TIME_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mcdt_pkg::t_req  i_req,
    output logic                 o_strobe,
    output mcdt_pkg::t_rsp       o_rsp
);

    mcdt_pkg::t_q_stat w_stat;
    mcdt_pkg::t_op     w_op;
    mcdt_pkg::t_op     w_head;
    logic              w_push;
    logic              w_pop;

    mcdt_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_op    (w_op)
    );

    mcdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    mcdt_back #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("Request pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("Request popped from an empty queue.");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("Queue reports full and empty at once.");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.last) |=> !o_strobe)
        else $error("Result strobed right after the final result of a tick.");

endmodule
`default_nettype wire

>>> verif/multi_channel_debounce_timer_checker.sv
// Checker that predicts and compares the fired-channel results of the debounce timer.
module multi_channel_debounce_timer_checker #(
    parameter int CHANNELS = mcdt_pkg::CHANNELS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_busy,
    input  wire mcdt_pkg::t_req   i_req,
    input  wire logic             i_strobe,
    input  wire mcdt_pkg::t_rsp   i_rsp,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [mcdt_pkg::TIME_BITS_DEF-1:0] tick_count;
    logic                               armed         [CHANNELS];
    logic [mcdt_pkg::TIME_BITS_DEF-1:0] start_tick    [CHANNELS];
    logic [mcdt_pkg::DELAY_W-1:0]       live_delay    [CHANNELS];
    logic                               live_periodic [CHANNELS];
    logic [mcdt_pkg::DELAY_W-1:0]       cfg_delay     [CHANNELS];
    logic                               cfg_periodic  [CHANNELS];

    mcdt_pkg::t_rsp expected_fires[$];
    int             fails;

    task automatic predict_request(input mcdt_pkg::t_req r);
        mcdt_pkg::t_rsp                     fired[$];
        mcdt_pkg::t_rsp                     one;
        logic [mcdt_pkg::TIME_BITS_DEF-1:0] elapsed;
        if (mcdt_pkg::t_cmd'(r.command) == mcdt_pkg::CMD_TICK) begin
            tick_count = tick_count + 1'b1;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (armed[ch]) begin
                    if (live_delay[ch] == '0) begin
                        armed[ch] = 1'b0;
                    end else begin
                        elapsed = tick_count - start_tick[ch];
                        if (elapsed > live_delay[ch]) begin
                            if (fired.size() < mcdt_pkg::MAX_RESULTS) begin
                                one.fired_channel = mcdt_pkg::CHAN_W'(ch);
                                one.last          = 1'b0;
                                fired.push_back(one);
                            end
                            if (live_periodic[ch]) begin
                                start_tick[ch] = tick_count;
                            end else begin
                                armed[ch] = 1'b0;
                            end
                        end
                    end
                end
            end
            if (fired.size() != 0) begin
                one      = fired.pop_back();
                one.last = 1'b1;
                fired.push_back(one);
            end
            foreach (fired[i]) expected_fires.push_back(fired[i]);
        end else if (r.channel < CHANNELS) begin
            case (mcdt_pkg::t_cmd'(r.command))
                mcdt_pkg::CMD_CONFIGURE: begin
                    cfg_delay[r.channel]    = r.delay_value;
                    cfg_periodic[r.channel] = r.periodic;
                end
                mcdt_pkg::CMD_ARM: begin
                    armed[r.channel]         = 1'b1;
                    start_tick[r.channel]    = tick_count;
                    live_delay[r.channel]    = cfg_delay[r.channel];
                    live_periodic[r.channel] = cfg_periodic[r.channel];
                end
                mcdt_pkg::CMD_CANCEL: begin
                    armed[r.channel]         = 1'b0;
                    live_delay[r.channel]    = '0;
                    live_periodic[r.channel] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : monitor
        mcdt_pkg::t_rsp want;
        if (!i_rst_n) begin
            tick_count = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                armed[ch]         = 1'b0;
                start_tick[ch]    = '0;
                live_delay[ch]    = '0;
                live_periodic[ch] = 1'b0;
                cfg_delay[ch]     = '0;
                cfg_periodic[ch]  = 1'b0;
            end
            expected_fires.delete();
            fails = 0;
        end else begin
            if (i_strobe) begin
                if (expected_fires.size() == 0) begin
                    $error("fired_channel expected none actual %0d", i_rsp.fired_channel);
                    fails++;
                end else begin
                    want = expected_fires.pop_front();
                    if (i_rsp.fired_channel !== want.fired_channel) begin
                        $error("fired_channel expected %0d actual %0d",
                               want.fired_channel, i_rsp.fired_channel);
                        fails++;
                    end
                    if (i_rsp.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, i_rsp.last);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) predict_request(i_req);
        end
        o_fail_count <= fails;
        o_pending    <= expected_fires.size();
    end

endmodule

>>> verif/multi_channel_debounce_timer_tb.sv
// Testbench top that drives timer requests into the debounce timer and gives the verdict.
module multi_channel_debounce_timer_tb;

    localparam int ITEM_TARGET    = 360;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    mcdt_pkg::t_req i_req   = '0;
    logic           busy;
    logic           o_strobe;
    mcdt_pkg::t_rsp o_rsp;
    int             fail_count;
    int             pending;
    int             sent         = 0;
    int             quiet_cycles = 0;

    multi_channel_debounce_timer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    multi_channel_debounce_timer_checker i_fire_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic mcdt_pkg::t_req make_req(mcdt_pkg::t_cmd cmd, int ch,
                                                logic [mcdt_pkg::DELAY_W-1:0] dly, logic per);
        mcdt_pkg::t_req r;
        r.command     = cmd;
        r.channel     = mcdt_pkg::CHAN_W'(ch);
        r.delay_value = dly;
        r.periodic    = per;
        return r;
    endfunction

    function automatic logic [mcdt_pkg::DELAY_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return $urandom();
        if (roll < 20) return mcdt_pkg::DELAY_W'(50);
        return mcdt_pkg::DELAY_W'($urandom_range(6, 1));
    endfunction

    task automatic send_req(input mcdt_pkg::t_req r);
        while (!(sent >= 150 && sent < 260) && $urandom_range(99) < 14) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int kind;
        int n;
        int ch;
        int chans[$];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(make_req(mcdt_pkg::CMD_CONFIGURE, 0, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_ARM, 0, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_CONFIGURE, 15, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_ARM, 15, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_CONFIGURE, 1, 32'd1, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_ARM, 1, 32'h5555_5555, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_CONFIGURE, 2, 32'd2, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_ARM, 2, 32'hAAAA_AAAA, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_CANCEL, 3, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_TICK, 15, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_TICK, 0, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_TICK, 7, 32'h1234_5678, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_ARM, 1, '0, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_TICK, 9, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_ARM, 1, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_TICK, 3, '0, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_TICK, 12, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_CANCEL, 2, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_TICK, 1, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_TICK, 2, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_TICK, 4, '0, 1'b0));
        send_req(make_req(mcdt_pkg::CMD_CANCEL, 15, '0, 1'b1));
        send_req(make_req(mcdt_pkg::CMD_TICK, 0, '0, 1'b0));
        wait_drained();

        while (sent < ITEM_TARGET) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                for (int c = 0; c < mcdt_pkg::CHANNELS_DEF; c++) begin
                    send_req(make_req(mcdt_pkg::CMD_CONFIGURE, c,
                                      mcdt_pkg::DELAY_W'($urandom_range(2, 1)),
                                      1'($urandom_range(1))));
                end
                for (int c = 0; c < mcdt_pkg::CHANNELS_DEF; c++) begin
                    send_req(make_req(mcdt_pkg::CMD_ARM, c, $urandom(),
                                      1'($urandom_range(1))));
                end
                repeat (4) send_req(make_req(mcdt_pkg::CMD_TICK, $urandom_range(15),
                                             $urandom(), 1'($urandom_range(1))));
            end else if (kind < 20) begin
                repeat (8) begin
                    send_req(make_req(mcdt_pkg::t_cmd'($urandom_range(3)), $urandom_range(15),
                                      $urandom(), 1'($urandom_range(1))));
                end
            end else begin
                chans.delete();
                n = $urandom_range(4, 1);
                repeat (n) chans.push_back($urandom_range(15));
                foreach (chans[i]) begin
                    send_req(make_req(mcdt_pkg::CMD_CONFIGURE, chans[i], pick_delay(),
                                      1'($urandom_range(1))));
                end
                foreach (chans[i]) begin
                    send_req(make_req(mcdt_pkg::CMD_ARM, chans[i], $urandom(),
                                      1'($urandom_range(1))));
                end
                n = $urandom_range(12, 2);
                repeat (n) begin
                    if ($urandom_range(99) < 15) begin
                        ch = chans[$urandom_range(chans.size() - 1)];
                        send_req(make_req($urandom_range(1) ? mcdt_pkg::CMD_ARM
                                                            : mcdt_pkg::CMD_CANCEL,
                                          ch, $urandom(), 1'($urandom_range(1))));
                    end
                    send_req(make_req(mcdt_pkg::CMD_TICK, $urandom_range(15), $urandom(),
                                      1'($urandom_range(1))));
                end
            end
            if ($urandom_range(3) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
